// File: rtl/pbt_pkg.sv
// Shared types, constants and helper functions for the Bezier trajectory core.
`default_nettype none
package pbt_pkg;

  // Table geometry
  localparam int MAX_PHASES = 16;
  localparam int LIMB_COUNT = 8;
  localparam int TRACKS     = LIMB_COUNT + 2;
  localparam int LANES      = 3;

  // Field widths
  localparam int COORD_W  = 32;
  localparam int DUR_W    = 16;
  localparam int PROG_W   = 17;
  localparam int PH_W     = 4;
  localparam int TR_W     = 4;
  localparam int ADDR_W   = PH_W + TR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int TRK_IDX_W = $clog2(TRACKS);

  // Fixed point
  localparam int FRAC_BITS = 16;
  localparam logic [PROG_W-1:0] T_ONE = PROG_W'(1) << FRAC_BITS;

  // Continuity divider: 33 bit difference times 17 bit duration
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + DUR_W + 1;
  localparam int MAG_W      = COORD_W + DUR_W;
  localparam int SUM_W      = MAG_W + 2;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = MAG_W / DIV_STEP;

  // Horner accumulator
  localparam int ACC_W = COORD_W + 6;
  localparam int MUL_W = ACC_W + PROG_W + 1;

  typedef enum logic [1:0] {
    OP_POINT = 2'd0,
    OP_DUR   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] SLOT_ORIGIN = 2'd0;
  localparam logic [1:0] SLOT_C1     = 2'd1;
  localparam logic [1:0] SLOT_END    = 2'd2;
  localparam logic [1:0] SLOT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDIV = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic [PH_W-1:0]           phase_index;
    logic [TR_W-1:0]           track;
    logic [1:0]                point_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [DUR_W-1:0]          phase_duration;
    logic [PROG_W-1:0]         progress;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [1:0]                status;
  } out_t;

  typedef logic [LANES-1:0][COORD_W-1:0] coord3_t;

  typedef struct packed {
    logic              eval;
    logic              flat;
    logic              ph_nz;
    logic              zdiv;
    logic              use_div;
    logic [PROG_W-1:0] t;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctrl;
    coord3_t          origin;
    coord3_t          prev_end;
    coord3_t          prev_c1;
    coord3_t          c1;
    coord3_t          last;
    logic [DUR_W-1:0] dprev;
    logic [DUR_W-1:0] dcur;
  } rd_t;

  typedef struct packed {
    ctrl_t            ctrl;
    coord3_t          p0;
    coord3_t          p2;
    coord3_t          p3;
    logic [LANES-1:0] neg;
  } side_t;

  typedef struct packed {
    ctrl_t   ctrl;
    logic    sat;
    coord3_t p0;
    coord3_t p1;
    coord3_t p2;
    coord3_t p3;
  } p1_t;

  // Saturation helpers on a wide signed value
  function automatic logic is_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    return (v > hi) || (v < lo);
  endfunction

  function automatic logic [COORD_W-1:0] clip(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/pbt_store.sv
// Point and duration tables with registered reads: first pipeline stage.
`default_nettype none
module pbt_store (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire pbt_pkg::in_t in_item,
  output logic             rd_valid_r,
  output pbt_pkg::rd_t     rd_r
);

  logic [pbt_pkg::LANES*pbt_pkg::COORD_W-1:0] c1_mem  [pbt_pkg::MEM_DEPTH];
  logic [pbt_pkg::LANES*pbt_pkg::COORD_W-1:0] end_mem [pbt_pkg::MEM_DEPTH];
  logic [pbt_pkg::LANES*pbt_pkg::COORD_W-1:0] origin_r [pbt_pkg::TRACKS];
  logic [pbt_pkg::DUR_W-1:0]                  dur_mem [pbt_pkg::MAX_PHASES];

  logic                            acc;
  logic                            trk_ok;
  logic                            flat;
  logic                            pt_wr;
  logic [pbt_pkg::PH_W-1:0]        ph_prev;
  logic [pbt_pkg::ADDR_W-1:0]      addr_cur;
  logic [pbt_pkg::ADDR_W-1:0]      addr_prev;
  logic [pbt_pkg::TRK_IDX_W-1:0]   trk_idx;
  pbt_pkg::coord3_t                wdata;
  pbt_pkg::ctrl_t                  ctrl_nxt;
  logic [pbt_pkg::PROG_W-1:0]      t_clamped;

  // Decode of the accepted item
  always_comb begin
    acc       = in_valid && en;
    trk_ok    = in_item.track < pbt_pkg::TR_W'(pbt_pkg::TRACKS);
    flat      = in_item.track >= pbt_pkg::TR_W'(pbt_pkg::LIMB_COUNT);
    trk_idx   = trk_ok ? in_item.track[pbt_pkg::TRK_IDX_W-1:0] : '0;
    ph_prev   = in_item.phase_index - pbt_pkg::PH_W'(1);
    addr_cur  = {in_item.phase_index, in_item.track};
    addr_prev = {ph_prev, in_item.track};
    pt_wr     = (in_item.operation == pbt_pkg::OP_POINT) && trk_ok &&
                (in_item.point_slot != pbt_pkg::SLOT_NONE) &&
                !((in_item.point_slot == pbt_pkg::SLOT_ORIGIN) &&
                  (in_item.phase_index != '0));
    wdata[0]  = in_item.coord_x;
    wdata[1]  = in_item.coord_y;
    wdata[2]  = flat ? '0 : in_item.coord_z;
    t_clamped = (in_item.progress > pbt_pkg::T_ONE) ? pbt_pkg::T_ONE : in_item.progress;
    ctrl_nxt.eval    = (in_item.operation == pbt_pkg::OP_EVAL) && trk_ok;
    ctrl_nxt.flat    = flat;
    ctrl_nxt.ph_nz   = in_item.phase_index != '0;
    ctrl_nxt.zdiv    = 1'b0;
    ctrl_nxt.use_div = 1'b0;
    ctrl_nxt.t       = t_clamped;
  end

  // Table writes on a write transfer
  always_ff @(posedge clk) begin
    if (acc && pt_wr) begin
      case (in_item.point_slot)
        pbt_pkg::SLOT_ORIGIN: origin_r[trk_idx] <= wdata;
        pbt_pkg::SLOT_C1:     c1_mem[addr_cur]  <= wdata;
        pbt_pkg::SLOT_END:    end_mem[addr_cur] <= wdata;
        default: ;
      endcase
    end
    if (acc && (in_item.operation == pbt_pkg::OP_DUR)) begin
      dur_mem[in_item.phase_index] <= in_item.phase_duration;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (en) begin
      rd_r.ctrl     <= ctrl_nxt;
      rd_r.origin   <= origin_r[trk_idx];
      rd_r.prev_end <= end_mem[addr_prev];
      rd_r.prev_c1  <= c1_mem[addr_prev];
      rd_r.c1       <= c1_mem[addr_cur];
      rd_r.last     <= end_mem[addr_cur];
      rd_r.dprev    <= dur_mem[ph_prev];
      rd_r.dcur     <= dur_mem[in_item.phase_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (en) begin
      rd_valid_r <= in_valid;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pbt_c1div.sv
// Derived first control point: difference, scaling and pipelined radix-4 divider.
`default_nettype none
module pbt_c1div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         rd_valid,
  input  wire pbt_pkg::rd_t rd,
  output logic              p1_valid_r,
  output pbt_pkg::p1_t      p1_r
);

  localparam int NS = pbt_pkg::DIV_STAGES;

  // Stage 2: select p0, form difference
  logic                                                s2_valid_r;
  pbt_pkg::side_t                                      s2_side_r, s2_side_nxt;
  logic [pbt_pkg::LANES-1:0][pbt_pkg::DIFF_W-1:0]      s2_diff_r, s2_diff_nxt;
  logic [pbt_pkg::DUR_W-1:0]                           s2_dprev_r, s2_dv_r, s2_dv_nxt;
  // Stage 3: product
  logic                                                s3_valid_r;
  pbt_pkg::side_t                                      s3_side_r;
  logic [pbt_pkg::LANES-1:0][pbt_pkg::PROD_W-1:0]      s3_prod_r, s3_prod_nxt;
  logic [pbt_pkg::DUR_W-1:0]                           s3_dv_r;
  // Stage 4: magnitude
  logic                                                s4_valid_r;
  pbt_pkg::side_t                                      s4_side_r, s4_side_nxt;
  logic [pbt_pkg::LANES-1:0][pbt_pkg::MAG_W-1:0]       s4_mag_r, s4_mag_nxt;
  logic [pbt_pkg::DUR_W-1:0]                           s4_dv_r;
  // Divider stages
  logic [NS-1:0]                                       dv_valid_r;
  pbt_pkg::side_t                                      dv_side_r [NS];
  logic [pbt_pkg::DUR_W-1:0]                           dv_div_r  [NS];
  logic [pbt_pkg::LANES-1:0][pbt_pkg::MAG_W-1:0]       dv_num_r  [NS];
  logic [pbt_pkg::LANES-1:0][pbt_pkg::MAG_W-1:0]       dv_num_nxt[NS];
  logic [pbt_pkg::LANES-1:0][pbt_pkg::DUR_W-1:0]       dv_rem_r  [NS];
  logic [pbt_pkg::LANES-1:0][pbt_pkg::DUR_W-1:0]       dv_rem_nxt[NS];
  pbt_pkg::p1_t                                        p1_nxt;

  logic signed [pbt_pkg::SUM_W-1:0] d_s;
  logic signed [pbt_pkg::SUM_W-1:0] sum_s;

  // Stage 2 logic
  always_comb begin
    s2_side_nxt.ctrl         = rd.ctrl;
    s2_side_nxt.ctrl.zdiv    = rd.ctrl.ph_nz && (rd.dcur == '0);
    s2_side_nxt.ctrl.use_div = rd.ctrl.ph_nz && (rd.dcur != '0);
    s2_side_nxt.p2           = rd.c1;
    s2_side_nxt.p3           = rd.last;
    s2_side_nxt.neg          = '0;
    for (int j = 0; j < pbt_pkg::LANES; j++) begin
      s2_side_nxt.p0[j] = rd.ctrl.ph_nz ? rd.prev_end[j] : rd.origin[j];
      s2_diff_nxt[j] = s2_side_nxt.ctrl.use_div ?
        pbt_pkg::DIFF_W'($signed(rd.prev_end[j])) - pbt_pkg::DIFF_W'($signed(rd.prev_c1[j])) :
        '0;
    end
    s2_dv_nxt = s2_side_nxt.ctrl.use_div ? rd.dcur : pbt_pkg::DUR_W'(1);
  end

  // Stage 3 multiply, stage 4 magnitude
  always_comb begin
    s4_side_nxt = s3_side_r;
    for (int j = 0; j < pbt_pkg::LANES; j++) begin
      s3_prod_nxt[j] = $signed(s2_diff_r[j]) * $signed({1'b0, s2_dprev_r});
      s4_side_nxt.neg[j] = s3_prod_r[j][pbt_pkg::PROD_W-1];
      s4_mag_nxt[j] = s4_side_nxt.neg[j] ?
        pbt_pkg::MAG_W'(-$signed(s3_prod_r[j])) : s3_prod_r[j][pbt_pkg::MAG_W-1:0];
    end
  end

  // Restoring divider, two quotient bits per stage
  always_comb begin
    logic [pbt_pkg::DUR_W-1:0] rem_t;
    logic [pbt_pkg::MAG_W-1:0] num_t;
    logic [pbt_pkg::DUR_W:0]   trial;
    logic [pbt_pkg::DUR_W-1:0] div_t;
    rem_t = '0;
    num_t = '0;
    trial = '0;
    div_t = '0;
    for (int k = 0; k < NS; k++) begin
      for (int j = 0; j < pbt_pkg::LANES; j++) begin
        if (k == 0) begin
          rem_t = '0;
          num_t = s4_mag_r[j];
          div_t = s4_dv_r;
        end else begin
          rem_t = dv_rem_r[k-1][j];
          num_t = dv_num_r[k-1][j];
          div_t = dv_div_r[k-1];
        end
        for (int b = 0; b < pbt_pkg::DIV_STEP; b++) begin
          trial = {rem_t, num_t[pbt_pkg::MAG_W-1]};
          if (trial >= {1'b0, div_t}) begin
            trial = trial - {1'b0, div_t};
            num_t = {num_t[pbt_pkg::MAG_W-2:0], 1'b1};
          end else begin
            num_t = {num_t[pbt_pkg::MAG_W-2:0], 1'b0};
          end
          rem_t = trial[pbt_pkg::DUR_W-1:0];
        end
        dv_num_nxt[k][j] = num_t;
        dv_rem_nxt[k][j] = rem_t;
      end
    end
  end

  // Apply sign, add to p0 and saturate
  always_comb begin
    p1_nxt.ctrl = dv_side_r[NS-1].ctrl;
    p1_nxt.p0   = dv_side_r[NS-1].p0;
    p1_nxt.p2   = dv_side_r[NS-1].p2;
    p1_nxt.p3   = dv_side_r[NS-1].p3;
    p1_nxt.sat  = 1'b0;
    d_s   = '0;
    sum_s = '0;
    for (int j = 0; j < pbt_pkg::LANES; j++) begin
      d_s = $signed({2'b00, dv_num_r[NS-1][j]});
      if (dv_side_r[NS-1].neg[j]) begin
        d_s = -d_s;
      end
      sum_s = pbt_pkg::SUM_W'($signed(dv_side_r[NS-1].p0[j])) + d_s;
      p1_nxt.p1[j] = pbt_pkg::clip(sum_s);
      p1_nxt.sat   = p1_nxt.sat | pbt_pkg::is_sat(sum_s);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r  <= s2_side_nxt;
      s2_diff_r  <= s2_diff_nxt;
      s2_dprev_r <= rd.dprev;
      s2_dv_r    <= s2_dv_nxt;
      s3_side_r  <= s2_side_r;
      s3_prod_r  <= s3_prod_nxt;
      s3_dv_r    <= s2_dv_r;
      s4_side_r  <= s4_side_nxt;
      s4_mag_r   <= s4_mag_nxt;
      s4_dv_r    <= s3_dv_r;
      dv_side_r[0] <= s4_side_r;
      dv_div_r[0]  <= s4_dv_r;
      for (int k = 1; k < NS; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
        dv_div_r[k]  <= dv_div_r[k-1];
      end
      for (int k = 0; k < NS; k++) begin
        dv_num_r[k] <= dv_num_nxt[k];
        dv_rem_r[k] <= dv_rem_nxt[k];
      end
      p1_r <= p1_nxt;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      dv_valid_r <= '0;
      p1_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= rd_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      dv_valid_r <= {dv_valid_r[NS-2:0], s4_valid_r};
      p1_valid_r <= dv_valid_r[NS-1];
    end
  end

endmodule
`default_nettype wire

// File: rtl/pbt_horner.sv
// Bezier coefficients and Horner evaluation, ending in the output register.
`default_nettype none
module pbt_horner (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         p1_valid,
  input  wire pbt_pkg::p1_t p1,
  output logic              out_valid_r,
  output pbt_pkg::out_t     out_r
);

  localparam int AW = pbt_pkg::ACC_W;
  localparam int MW = pbt_pkg::MUL_W;
  localparam int L  = pbt_pkg::LANES;

  typedef logic [L-1:0][AW-1:0] acc3_t;
  typedef logic [L-1:0][MW-1:0] mul3_t;

  logic [5:0]     v_r;
  pbt_pkg::ctrl_t c_r [6];
  logic [5:0]     sat_r;

  acc3_t h0_a_r, h0_b_r, h0_c_r, h0_p0_r;
  acc3_t h1_b_r, h1_c_r, h1_p0_r;
  mul3_t h1_m_r;
  acc3_t h2_acc_r, h2_c_r, h2_p0_r;
  mul3_t h3_m_r;
  acc3_t h3_c_r, h3_p0_r;
  acc3_t h4_acc_r, h4_p0_r;
  mul3_t h5_m_r;
  acc3_t h5_p0_r;

  acc3_t a_nxt, b_nxt, c_nxt, p0_nxt, acc2_nxt, acc4_nxt;
  mul3_t m1_nxt, m3_nxt, m5_nxt;
  pbt_pkg::out_t out_nxt;

  logic signed [AW-1:0]             e0, e1, e2, e3;
  logic signed [AW-1:0]             fin;
  logic signed [pbt_pkg::SUM_W-1:0] fin_w;
  logic [L-1:0][pbt_pkg::COORD_W-1:0] res;
  logic                             sat_any;

  // Coefficients and the three multiply/add steps
  always_comb begin
    for (int j = 0; j < L; j++) begin
      e0 = AW'($signed(p1.p0[j]));
      e1 = AW'($signed(p1.p1[j]));
      e2 = AW'($signed(p1.p2[j]));
      e3 = AW'($signed(p1.p3[j]));
      a_nxt[j]  = -e0 + 3 * e1 - 3 * e2 + e3;
      b_nxt[j]  = 3 * e0 - 6 * e1 + 3 * e2;
      c_nxt[j]  = -3 * e0 + 3 * e1;
      p0_nxt[j] = e0;
      m1_nxt[j] = $signed(h0_a_r[j]) * $signed({1'b0, c_r[0].t});
      acc2_nxt[j] = AW'($signed(h1_m_r[j]) >>> pbt_pkg::FRAC_BITS) + $signed(h1_b_r[j]);
      m3_nxt[j] = $signed(h2_acc_r[j]) * $signed({1'b0, c_r[2].t});
      acc4_nxt[j] = AW'($signed(h3_m_r[j]) >>> pbt_pkg::FRAC_BITS) + $signed(h3_c_r[j]);
      m5_nxt[j] = $signed(h4_acc_r[j]) * $signed({1'b0, c_r[4].t});
    end
  end

  // Final add, saturation and status
  always_comb begin
    sat_any = sat_r[5];
    fin     = '0;
    fin_w   = '0;
    for (int j = 0; j < L; j++) begin
      fin    = AW'($signed(h5_m_r[j]) >>> pbt_pkg::FRAC_BITS) + $signed(h5_p0_r[j]);
      fin_w  = pbt_pkg::SUM_W'(fin);
      res[j] = pbt_pkg::clip(fin_w);
      sat_any = sat_any | pbt_pkg::is_sat(fin_w);
    end
    out_nxt = '0;
    if (c_r[5].eval) begin
      out_nxt.pos_x = res[0];
      out_nxt.pos_y = res[1];
      out_nxt.pos_z = c_r[5].flat ? '0 : res[2];
      if (sat_any) begin
        out_nxt.status = pbt_pkg::ST_SAT;
      end else if (c_r[5].zdiv) begin
        out_nxt.status = pbt_pkg::ST_ZDIV;
      end else begin
        out_nxt.status = pbt_pkg::ST_OK;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]   <= p1.ctrl;
      sat_r[0] <= p1.sat;
      for (int k = 1; k < 6; k++) begin
        c_r[k]   <= c_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
      h0_a_r   <= a_nxt;
      h0_b_r   <= b_nxt;
      h0_c_r   <= c_nxt;
      h0_p0_r  <= p0_nxt;
      h1_m_r   <= m1_nxt;
      h1_b_r   <= h0_b_r;
      h1_c_r   <= h0_c_r;
      h1_p0_r  <= h0_p0_r;
      h2_acc_r <= acc2_nxt;
      h2_c_r   <= h1_c_r;
      h2_p0_r  <= h1_p0_r;
      h3_m_r   <= m3_nxt;
      h3_c_r   <= h2_c_r;
      h3_p0_r  <= h2_p0_r;
      h4_acc_r <= acc4_nxt;
      h4_p0_r  <= h3_p0_r;
      h5_m_r   <= m5_nxt;
      h5_p0_r  <= h4_p0_r;
      out_r    <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[4:0], p1_valid};
      out_valid_r <= v_r[5];
    end
  end

endmodule
`default_nettype wire

// File: rtl/piecewise_bezier_trajectory_core.sv
// Top level of the piecewise cubic Bezier trajectory core.
//
//  Channel | Ports                          | Direction | Transfer when
//  --------+--------------------------------+-----------+----------------------
//  input   | in_valid, in_stall, in_item    | in        | in_valid && !in_stall
//  result  | out_valid, out_stall, out_item | out       | out_valid && !out_stall
//
// One item enters per cycle unless the input is stalled; every item passes 36
// register stages between the input transfer and its result.
// Most of that depth is the 24-stage radix-4 divider for the continuity point and
// the three Horner multiply steps. Reset clears only valid bits; the tables are
// undefined until written. A stalled result freezes the whole pipeline, so the
// input is stalled in the same cycle and nothing is lost or repeated.
`default_nettype none
module piecewise_bezier_trajectory_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pbt_pkg::in_t  in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pbt_pkg::out_t      out_item
);

  logic         en;
  logic         rd_valid;
  pbt_pkg::rd_t rd;
  logic         p1_valid;
  pbt_pkg::p1_t p1;

  // Pipeline advances unless a held result is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pbt_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .rd_valid_r (rd_valid),
    .rd_r       (rd)
  );

  pbt_c1div u_c1div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .rd_valid   (rd_valid),
    .rd         (rd),
    .p1_valid_r (p1_valid),
    .p1_r       (p1)
  );

  pbt_horner u_horner (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .p1_valid    (p1_valid),
    .p1          (p1),
    .out_valid_r (out_valid),
    .out_r       (out_item)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the piecewise Bezier trajectory core.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import pbt_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;

  piecewise_bezier_trajectory_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // Shadow copy of the point and duration tables
  logic signed [31:0] pt_shadow [MAX_PHASES][TRACKS][3][3];
  logic [15:0]        dur_shadow [MAX_PHASES];

  in_t  pending_q [$];
  out_t expected_q [$];
  bit   calm;
  int   mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit over32(input longint v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Expected result of one item; point and duration writes update the shadow
  function automatic out_t trajectory_step(input in_t it);
    out_t   r;
    int     ph, tr, sl;
    bit     addr_ok, flat, sat, zdiv;
    longint t, p0, p1, p2, p3, a, b, c, acc, d;
    r = '0;
    ph = int'(it.phase_index);
    tr = int'(it.track);
    sl = int'(it.point_slot);
    addr_ok = tr < TRACKS;
    flat = tr >= LIMB_COUNT;
    case (op_t'(it.operation))
      OP_POINT: begin
        if (addr_ok && sl <= SLOT_END && !(sl == SLOT_ORIGIN && ph != 0)) begin
          pt_shadow[ph][tr][sl][0] = it.coord_x;
          pt_shadow[ph][tr][sl][1] = it.coord_y;
          pt_shadow[ph][tr][sl][2] = flat ? 32'sd0 : it.coord_z;
        end
      end
      OP_DUR: dur_shadow[ph] = it.phase_duration;
      OP_EVAL: begin
        if (addr_ok) begin
          sat = 0;
          t = (it.progress > T_ONE) ? longint'(T_ONE) : longint'(it.progress);
          zdiv = (ph > 0) && (dur_shadow[ph] == 0);
          for (int j = 0; j < 3; j++) begin
            if (ph == 0) begin
              p0 = pt_shadow[0][tr][SLOT_ORIGIN][j];
              p1 = p0;
            end else begin
              p0 = pt_shadow[ph-1][tr][SLOT_END][j];
              if (zdiv) begin
                p1 = p0;
              end else begin
                d = (p0 - longint'(pt_shadow[ph-1][tr][SLOT_C1][j])) *
                    longint'(dur_shadow[ph-1]);
                d = d / longint'(dur_shadow[ph]);
                if (over32(p0 + d)) sat = 1;
                p1 = longint'($signed(clamp32(p0 + d)));
              end
            end
            p2 = pt_shadow[ph][tr][SLOT_C1][j];
            p3 = pt_shadow[ph][tr][SLOT_END][j];
            a = -p0 + 3 * p1 - 3 * p2 + p3;
            b = 3 * p0 - 6 * p1 + 3 * p2;
            c = -3 * p0 + 3 * p1;
            acc = ((a * t) >>> FRAC_BITS) + b;
            acc = ((acc * t) >>> FRAC_BITS) + c;
            acc = ((acc * t) >>> FRAC_BITS) + p0;
            if (over32(acc)) sat = 1;
            case (j)
              0: r.pos_x = clamp32(acc);
              1: r.pos_y = clamp32(acc);
              default: r.pos_z = flat ? 32'sd0 : clamp32(acc);
            endcase
          end
          r.status = sat ? ST_SAT : (zdiv ? ST_ZDIV : ST_OK);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: one transfer per accepted item, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(trajectory_step(in_item));
      if (in_valid && in_stall) begin
        // hold
      end else if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
        in_valid <= 1'b1;
        in_item  <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 26);
  end

  // Monitor: compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        e = expected_q.pop_front();
        if (out_item.pos_x !== e.pos_x || out_item.pos_y !== e.pos_y ||
            out_item.pos_z !== e.pos_z || out_item.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                     e.pos_x, e.pos_y, e.pos_z, e.status, out_item.pos_x,
                     out_item.pos_y, out_item.pos_z, out_item.status);
        end
      end
    end
  end

  // Item builders: unused fields carry random noise
  function automatic in_t noise_item();
    in_t         it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic in_t point_item(int ph, int tr, int sl,
                                     logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t it;
    it = noise_item();
    it.operation = OP_POINT;
    it.phase_index = PH_W'(ph);
    it.track = TR_W'(tr);
    it.point_slot = 2'(sl);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    return it;
  endfunction

  function automatic in_t dur_item(int ph, logic [15:0] dv);
    in_t it;
    it = noise_item();
    it.operation = OP_DUR;
    it.phase_index = PH_W'(ph);
    it.phase_duration = dv;
    return it;
  endfunction

  function automatic in_t eval_item(int ph, int tr, logic [16:0] t);
    in_t it;
    it = noise_item();
    it.operation = OP_EVAL;
    it.phase_index = PH_W'(ph);
    it.track = TR_W'(tr);
    it.progress = t;
    return it;
  endfunction

  function automatic logic [16:0] rand_progress();
    case ($urandom_range(7))
      0: return 17'($urandom_range(131071, 65537));
      1: return $urandom_range(1) ? T_ONE : 17'd0;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [15:0] rand_duration();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'hffff;
      default: return 16'($urandom_range(2000, 1));
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    int  k;
    int  ph;
    k = $urandom_range(99);
    ph = $urandom_range(15);
    if (k < 45) begin
      it = eval_item(ph, $urandom_range(TRACKS - 1), rand_progress());
    end else if (k < 80) begin
      it = point_item(ph, $urandom_range(TRACKS - 1),
                      (ph == 0) ? $urandom_range(2) : $urandom_range(2, 1),
                      rand_coord(), rand_coord(), rand_coord());
    end else if (k < 92) begin
      it = dur_item(ph, rand_duration());
    end else begin
      // ignored or invalid: bad op, bad track, bad slot
      it = noise_item();
      if (it.operation != OP_NONE && it.track < TRACKS) begin
        it.operation = OP_POINT;
        it.point_slot = $urandom_range(1) ? SLOT_NONE : SLOT_ORIGIN;
        if (it.point_slot == SLOT_ORIGIN && it.phase_index == 0)
          it.phase_index = PH_W'(1);
      end
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    out_stall = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    calm = 0;
    mismatches = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every table entry so that no evaluation reads an unwritten one
    for (int p = 0; p < MAX_PHASES; p++) begin
      pending_q.push_back(dur_item(p, 16'($urandom_range(2000, 1))));
      for (int tr = 0; tr < TRACKS; tr++)
        for (int sl = (p == 0) ? 0 : 1; sl < 3; sl++)
          pending_q.push_back(point_item(p, tr, sl, rand_coord(), rand_coord(),
                                         rand_coord()));
    end
    wait_drained();

    // Directed: extremes, clamping, zero duration, ignored items, 2D tracks
    pending_q.push_back(point_item(0, 0, SLOT_ORIGIN, 32'h80000000, 32'h7fffffff,
                                   32'h80000000));
    pending_q.push_back(point_item(0, 0, SLOT_END, 32'h7fffffff, 32'h80000000,
                                   32'h7fffffff));
    pending_q.push_back(eval_item(0, 0, 17'd0));
    pending_q.push_back(eval_item(0, 0, T_ONE));
    pending_q.push_back(eval_item(0, 0, 17'h1ffff));
    pending_q.push_back(eval_item(1, 0, 17'd32768));
    pending_q.push_back(dur_item(1, 16'hffff));
    pending_q.push_back(dur_item(2, 16'd1));
    pending_q.push_back(eval_item(2, 0, 17'd40000));
    pending_q.push_back(dur_item(3, 16'd0));
    pending_q.push_back(eval_item(3, 5, 17'd20000));
    pending_q.push_back(point_item(4, TRACKS - 1, SLOT_END, 32'h00010000, 32'hffff0000,
                                   32'h12345678));
    pending_q.push_back(eval_item(4, TRACKS - 1, 17'd50000));
    pending_q.push_back(eval_item(15, LIMB_COUNT, 17'd1));
    pending_q.push_back(eval_item(5, 15, 17'd100));
    pending_q.push_back(point_item(5, 12, SLOT_END, 1, 2, 3));
    pending_q.push_back(point_item(5, 2, SLOT_NONE, 1, 2, 3));
    pending_q.push_back(point_item(6, 2, SLOT_ORIGIN, 1, 2, 3));
    pending_q.push_back(eval_item(6, 2, 17'd30000));
    begin
      in_t junk;
      junk = noise_item();
      junk.operation = OP_NONE;
      pending_q.push_back(junk);
    end
    pending_q.push_back(dur_item(3, 16'd500));
    wait_drained();

    // Random part, with one stretch free of idling on both sides
    for (int i = 0; i < 930; i++) pending_q.push_back(random_item());
    while (pending_q.size() > 650) @(posedge clk);
    calm = 1;
    while (pending_q.size() > 450) @(posedge clk);
    calm = 0;
    wait_drained();
    repeat (60) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #(20 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// File: piecewise_bezier_trajectory_core.f
rtl/pbt_pkg.sv
rtl/pbt_store.sv
rtl/pbt_c1div.sv
rtl/pbt_horner.sv
rtl/piecewise_bezier_trajectory_core.sv
tb/tb.sv
